/* sv/pcbrm_pkg.sv */
package pcbrm_pkg;

  // field widths
  localparam int unsigned CoreW  = 4;
  localparam int unsigned TickW  = 64;
  localparam int unsigned RatioW = 14;
  localparam int unsigned HalfW  = TickW / 2;

  // full product busy * scale and one partial product of a half word
  localparam int unsigned ProdW = TickW + RatioW;
  localparam int unsigned PartW = HalfW + RatioW;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = ((CoreW + 2 * TickW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((CoreW + RatioW + 7) / 8) * 8;

  // one step of the ratio is a hundredth of a percent
  localparam logic [RatioW-1:0] Scale = RatioW'(10000);

  // stored counter pair of one core
  typedef struct packed {
    logic [TickW-1:0] idle;
    logic [TickW-1:0] total;
  } counters_t;

endpackage

/* sv/pcbrm_store.sv */
module pcbrm_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output pcbrm_pkg::counters_t  rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  pcbrm_pkg::counters_t  wr_data_i
);
  import pcbrm_pkg::*;

  counters_t        mem_q [Depth];
  counters_t        rd_q;
  logic [Depth-1:0] vld_q;
  logic             rd_vld_q;

  // counter memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // written flags, cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // an entry never written reads as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* sv/pcbrm_div.sv */
module pcbrm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pcbrm_pkg::TickW-1:0]    busy_i,
  input  logic [pcbrm_pkg::TickW-1:0]    dt_i,
  output logic                           done_o,
  output logic [pcbrm_pkg::RatioW-1:0]   quot_o
);
  import pcbrm_pkg::*;

  localparam int unsigned CntW = $clog2(RatioW);

  typedef enum logic [4:0] {
    DV_IDLE   = 5'b00001,
    DV_MUL_LO = 5'b00010,
    DV_MUL_HI = 5'b00100,
    DV_SUM    = 5'b01000,
    DV_STEP   = 5'b10000
  } dv_state_e;

  dv_state_e         state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [TickW-1:0]  busy_q, dt_q, rem_q;
  logic [PartW-1:0]  lo_q, hi_q;
  logic [RatioW-1:0] num_q;

  logic [HalfW-1:0]  mul_a;
  logic [PartW-1:0]  mul_p;
  logic [ProdW-1:0]  prod;
  logic [TickW:0]    shifted;
  logic [TickW:0]    diff;
  logic              ge;

  // one shared 32 x 14 multiplier for both half words
  assign mul_a = (state_q == DV_MUL_LO) ? busy_q[HalfW-1:0] : busy_q[TickW-1:HalfW];
  assign mul_p = PartW'(mul_a) * PartW'(Scale);

  // join the partial products
  assign prod = (ProdW'(hi_q) << HalfW) + ProdW'(lo_q);

  // restoring step, the remainder stays below the divisor
  assign shifted = {rem_q, num_q[RatioW-1]};
  assign diff    = shifted - {1'b0, dt_q};
  assign ge      = (shifted >= {1'b0, dt_q});

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          state_d = DV_MUL_LO;
        end
      end
      DV_MUL_LO: state_d = DV_MUL_HI;
      DV_MUL_HI: state_d = DV_SUM;
      DV_SUM: begin
        cnt_d   = CntW'(RatioW - 1);
        state_d = DV_STEP;
      end
      DV_STEP: begin
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if ((state_q == DV_IDLE) && start_i) begin
      busy_q <= busy_i;
      dt_q   <= dt_i;
    end
    if (state_q == DV_MUL_LO) begin
      lo_q <= mul_p;
    end
    if (state_q == DV_MUL_HI) begin
      hi_q <= mul_p;
    end
    if (state_q == DV_SUM) begin
      rem_q <= prod[ProdW-1:RatioW];
      num_q <= prod[RatioW-1:0];
    end
    if (state_q == DV_STEP) begin
      rem_q <= ge ? diff[TickW-1:0] : shifted[TickW-1:0];
      num_q <= {num_q[RatioW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

/* sv/per_core_busy_ratio_meter_top.sv */
// Per-core busy ratio meter. Each request carries a core index with that core's cumulative
// total and idle tick counters; the block answers with the busy share since the previous
// sample of the same core, in hundredths of a percent, truncated, and a flag that is low
// when the total counter did not advance (or the core index is not below CORES). A delta
// whose counter went backwards counts as zero. The previous counters live in a small
// memory with a registered read port; reset clears it at once through per-entry written
// flags, so there is no clearing pass. Samples are handled one at a time: a request is taken
// only after the previous one has passed the delta and busy steps, the shared 32 x 14
// multiplier and the 14-step restoring divider when a ratio is formed, and has been loaded
// into the output register, which waits while the output is stalled. A finished result
// waits in the output register while the next request is taken.
module per_core_busy_ratio_meter_top #(
  parameter int unsigned CORES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // core_index [3:0], total_ticks [67:4], idle_ticks [131:68], zero pad
  input  logic [pcbrm_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // core_number [3:0], busy_centipercent [17:4], zero pad
  output logic [pcbrm_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // ratio_valid [0]
  output logic                              m_axis_tuser_o
);
  import pcbrm_pkg::*;

  localparam int unsigned AddrW = (CORES > 1) ? $clog2(CORES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DELTA = 5'b00010,
    ST_BUSY  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              m_valid_q, m_valid_d;
  logic              load_out;

  logic [CoreW-1:0]  in_core;
  counters_t         in_cnt;
  logic              in_range;
  logic              accept;

  logic [CoreW-1:0]  core_q;
  counters_t         cur_q;
  logic              in_range_q;
  logic [TickW-1:0]  dt_q, di_q;
  logic              ratio_valid_q;
  logic [RatioW-1:0] util_q;
  logic [OutDataW-1:0] m_data_q;
  logic              m_user_q;

  counters_t         prev;
  logic [TickW-1:0]  dt_d, di_d, busy;
  logic              ratio_ok;
  logic              div_start, div_done;
  logic [RatioW-1:0] div_quot;

  // request fields
  assign in_core      = s_axis_tdata_i[CoreW-1:0];
  assign in_cnt.total = s_axis_tdata_i[CoreW +: TickW];
  assign in_cnt.idle  = s_axis_tdata_i[CoreW + TickW +: TickW];
  assign in_range     = (32'(in_core) < CORES);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // previous counters
  pcbrm_store #(
    .Depth (CORES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (AddrW'(in_core)),
    .rd_data_o (prev),
    .wr_en_i   ((state_q == ST_DELTA) && in_range_q),
    .wr_addr_i (AddrW'(core_q)),
    .wr_data_i (cur_q)
  );

  // deltas, a counter that went backwards gives zero
  assign dt_d = (cur_q.total >= prev.total) ? (cur_q.total - prev.total) : '0;
  assign di_d = (cur_q.idle >= prev.idle) ? (cur_q.idle - prev.idle) : '0;

  // busy time floored at zero
  assign busy     = (dt_q > di_q) ? (dt_q - di_q) : '0;
  assign ratio_ok = in_range_q && (dt_q != '0);

  assign div_start = (state_q == ST_BUSY) && ratio_ok;

  pcbrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .busy_i  (busy),
    .dt_i    (dt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // output register may take the result when empty or being drained
  assign load_out = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

  // control sequencer
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DELTA;
        end
      end
      ST_DELTA: state_d = ST_BUSY;
      ST_BUSY:  state_d = ratio_ok ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      core_q     <= in_core;
      cur_q      <= in_cnt;
      in_range_q <= in_range;
    end
    if (state_q == ST_DELTA) begin
      dt_q <= dt_d;
      di_q <= di_d;
    end
    if (state_q == ST_BUSY) begin
      ratio_valid_q <= ratio_ok;
      util_q        <= '0;
    end
    if ((state_q == ST_DIV) && div_done) begin
      util_q <= div_quot;
    end
    if (load_out) begin
      m_data_q <= OutDataW'({util_q, core_q});
      m_user_q <= ratio_valid_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

/* sv/pcbrm_chk.sv */
module pcbrm_chk #(
  parameter int unsigned CORES = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [pcbrm_pkg::InDataW-1:0]    s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [pcbrm_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);
  import pcbrm_pkg::*;

  logic [CoreW-1:0]  out_core;
  logic [RatioW-1:0] out_ratio;

  assign out_core  = m_axis_tdata_o[CoreW-1:0];
  assign out_ratio = m_axis_tdata_o[CoreW +: RatioW];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // ratio never exceeds full scale
  a_ratio_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_ratio <= Scale))
    else $error("ratio above full scale");

  // no ratio means a zero ratio field
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (out_ratio == '0))
    else $error("nonzero ratio without valid flag");

  // an unknown core never carries a ratio
  a_core_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (32'(out_core) >= CORES) |-> !m_axis_tuser_o)
    else $error("ratio for core outside the table");

  // one sample at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while a sample is in work");

endmodule

bind per_core_busy_ratio_meter_top pcbrm_chk #(.CORES(CORES)) u_chk (.*);
